// ===== hw/rtl/packet_header_classifier_defines.svh =====
// Assertion macros for the packet header classifier
`ifndef PACKET_HEADER_CLASSIFIER_DEFINES_SVH
`define PACKET_HEADER_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
`define PHC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PHC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PHC_ASSERT_IMP(label, ante, cons, msg)
`define PHC_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/phc_pkg.sv =====
`default_nettype none

package phc_pkg;

	localparam int MAX_FRAME_BYTES = 65536;
	localparam int POS_W = 17;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int REG_W = 16;

	localparam logic [1:0] REG_UDP_DEST_PORT = 2'd0;
	localparam logic [1:0] REG_UDP_SRC_LOW = 2'd1;
	localparam logic [1:0] REG_UDP_SRC_HIGH = 2'd2;
	localparam logic [1:0] REG_USER_OFFSET = 2'd3;

	localparam logic [1:0] CLASS_DROP = 2'd0;
	localparam logic [1:0] CLASS_GET = 2'd1;
	localparam logic [1:0] CLASS_USER = 2'd2;

	localparam logic [15:0] ETH_TYPE_VLAN = 16'h8100;
	localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
	localparam logic [7:0] IP_PROTO_TCP = 8'd6;
	localparam logic [7:0] IP_PROTO_UDP = 8'd17;

	localparam logic [POS_W-1:0] ETH_TYPE_POS = POS_W'(12);

	typedef struct packed {
		logic [REG_W-1:0] udp_dest_port;
		logic [REG_W-1:0] udp_src_port_low;
		logic [REG_W-1:0] udp_src_port_high;
		logic [REG_W-1:0] user_number_offset;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		udp_dest_port: 16'd8000,
		udp_src_port_low: 16'd4000,
		udp_src_port_high: 16'd4100,
		user_number_offset: 16'd49
	};

	typedef struct packed {
		logic [1:0] frame_class;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [31:0] user_number;
		logic [POS_W-1:0] payload_start;
		logic [POS_W-1:0] frame_length;
	} result_t;

	function automatic logic [7:0] get_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = 8'h47;
			2'd1: c = 8'h45;
			2'd2: c = 8'h54;
			default: c = 8'h20;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/phc_parser.sv =====
`default_nettype none

module phc_parser (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       advance,
	input  wire logic [7:0]                 data_byte,
	input  wire logic                       last_byte,
	input  wire phc_pkg::cfg_t              cfg,
	output phc_pkg::result_t                result
);
	import phc_pkg::*;

	typedef enum logic [3:0] {
		PH_ETH,
		PH_IP,
		PH_TCP,
		PH_GET,
		PH_UDP,
		PH_HTTP,
		PH_UDPOK,
		PH_NOIP,
		PH_DROPIP
	} phase_t;

	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);

	phase_t           phase_q, phase_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [POS_W-1:0] nh_q, nh_n;
	logic [15:0]      type_q, type_n;
	logic [7:0]       proto_q, proto_n;
	logic [31:0]      src_addr_q, src_addr_n;
	logic [31:0]      dst_addr_q, dst_addr_n;
	logic [15:0]      src_port_q, src_port_n;
	logic [15:0]      dst_port_q, dst_port_n;
	logic [31:0]      acc_q, acc_n;
	logic [2:0]       gmc_q, gmc_n;
	logic [POS_W-1:0] rel;
	logic [POS_W-1:0] off_ext;
	logic [POS_W-1:0] off_end;
	logic [15:0]      type_full;
	logic [3:0]       doff;
	logic             addr_ok;

	assign off_ext = {1'b0, cfg.user_number_offset};
	assign off_end = off_ext + POS_W'(4);
	assign rel = pos_q - nh_q;
	assign type_full = type_q | {8'h00, data_byte};
	assign doff = data_byte[7:4];

	always_comb begin
		phase_n = phase_q;
		pos_n = pos_q;
		nh_n = nh_q;
		type_n = type_q;
		proto_n = proto_q;
		src_addr_n = src_addr_q;
		dst_addr_n = dst_addr_q;
		src_port_n = src_port_q;
		dst_port_n = dst_port_q;
		acc_n = acc_q;
		gmc_n = gmc_q;
		if (pos_q < MAX_POS) begin
			pos_n = pos_q + POS_W'(1);
			if (pos_q >= off_ext && (pos_q - off_ext) < POS_W'(4)) begin
				acc_n = {acc_q[23:0], data_byte};
			end
			if (pos_q >= nh_q) begin
				unique case (phase_q)
					PH_ETH: begin
						if (rel == POS_W'(0)) begin
							type_n = {data_byte, 8'h00};
						end else if (rel == POS_W'(1)) begin
							type_n = type_full;
							if (type_full == ETH_TYPE_VLAN) begin
								nh_n = nh_q + POS_W'(4);
							end else if (type_full == ETH_TYPE_IPV4) begin
								nh_n = nh_q + POS_W'(2);
								phase_n = PH_IP;
							end else begin
								phase_n = PH_NOIP;
							end
						end
					end
					PH_IP: begin
						if (rel == POS_W'(9)) begin
							proto_n = data_byte;
						end else if (rel >= POS_W'(12) && rel <= POS_W'(15)) begin
							src_addr_n = {src_addr_q[23:0], data_byte};
						end else if (rel >= POS_W'(16) && rel <= POS_W'(19)) begin
							dst_addr_n = {dst_addr_q[23:0], data_byte};
						end
						if (rel == POS_W'(19)) begin
							nh_n = nh_q + POS_W'(20);
							if (proto_q == IP_PROTO_TCP) begin
								phase_n = PH_TCP;
							end else if (proto_q == IP_PROTO_UDP) begin
								phase_n = PH_UDP;
							end else begin
								phase_n = PH_DROPIP;
							end
						end
					end
					PH_TCP: begin
						if (rel == POS_W'(12)) begin
							if (doff < 4'd4) begin
								phase_n = PH_DROPIP;
							end else begin
								nh_n = nh_q + POS_W'({doff, 2'b00});
								gmc_n = 3'd0;
								phase_n = PH_GET;
							end
						end
					end
					PH_GET: begin
						if (data_byte == get_char(gmc_q[1:0])) begin
							gmc_n = gmc_q + 3'd1;
							if (gmc_n[2]) begin
								phase_n = PH_HTTP;
							end
						end else begin
							phase_n = PH_DROPIP;
						end
					end
					PH_UDP: begin
						if (rel <= POS_W'(1)) begin
							src_port_n = {src_port_q[7:0], data_byte};
						end else if (rel <= POS_W'(3)) begin
							dst_port_n = {dst_port_q[7:0], data_byte};
						end
						if (rel == POS_W'(3)) begin
							if (dst_port_n == cfg.udp_dest_port
								&& src_port_n >= cfg.udp_src_port_low
								&& src_port_n <= cfg.udp_src_port_high) begin
								phase_n = PH_UDPOK;
							end else begin
								phase_n = PH_DROPIP;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		addr_ok = phase_n == PH_TCP || phase_n == PH_GET || phase_n == PH_UDP
			|| phase_n == PH_HTTP || phase_n == PH_UDPOK || phase_n == PH_DROPIP;
		result.frame_class = CLASS_DROP;
		result.user_number = 32'd0;
		result.payload_start = '0;
		if (phase_n == PH_HTTP) begin
			result.frame_class = CLASS_GET;
			result.payload_start = nh_n;
		end else if (phase_n == PH_UDPOK && pos_n >= off_end) begin
			result.frame_class = CLASS_USER;
			result.user_number = acc_n;
		end
		result.source_address = addr_ok ? src_addr_q : 32'd0;
		result.dest_address = addr_ok ? dst_addr_n : 32'd0;
		result.frame_length = pos_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ETH;
			pos_q <= '0;
			nh_q <= ETH_TYPE_POS;
			type_q <= '0;
			proto_q <= '0;
			src_addr_q <= '0;
			dst_addr_q <= '0;
			src_port_q <= '0;
			dst_port_q <= '0;
			acc_q <= '0;
			gmc_q <= '0;
		end else if (advance) begin
			if (last_byte) begin
				phase_q <= PH_ETH;
				pos_q <= '0;
				nh_q <= ETH_TYPE_POS;
				type_q <= '0;
				proto_q <= '0;
				src_addr_q <= '0;
				dst_addr_q <= '0;
				src_port_q <= '0;
				dst_port_q <= '0;
				acc_q <= '0;
				gmc_q <= '0;
			end else begin
				phase_q <= phase_n;
				pos_q <= pos_n;
				nh_q <= nh_n;
				type_q <= type_n;
				proto_q <= proto_n;
				src_addr_q <= src_addr_n;
				dst_addr_q <= dst_addr_n;
				src_port_q <= src_port_n;
				dst_port_q <= dst_port_n;
				acc_q <= acc_n;
				gmc_q <= gmc_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/packet_header_classifier.sv =====
// The last byte's result is taken from the parser into the result register.
// One byte per cycle unless stalled; frames follow back to back with no gap.
// A last byte waits in the input register only while a full result is not taken.
// Reset: clears the parse state, the valid flags and the registers to their defaults.
`default_nettype none
`include "packet_header_classifier_defines.svh"

module packet_header_classifier (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         data_valid,
	output logic                              data_ready,
	input  wire logic [7:0]                   data_byte,
	input  wire logic                         last_byte,
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output logic [1:0]                        frame_class,
	output logic [31:0]                       source_address,
	output logic [31:0]                       dest_address,
	output logic [31:0]                       user_number,
	output logic [phc_pkg::POS_W-1:0]         payload_start,
	output logic [phc_pkg::POS_W-1:0]         frame_length,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [phc_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [phc_pkg::DATA_W-1:0]   pwdata,
	output logic [phc_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);
	import phc_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        stall_s1;
	logic        advance;
	result_t     parse_result;
	result_t     result_s2;
	logic        valid_s2;
	logic [1:0]  reg_index;
	logic        cfg_write;

	assign pready = 1'b1;
	assign reg_index = paddr[ADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_write) begin
			unique case (reg_index)
				REG_UDP_DEST_PORT: cfg_q.udp_dest_port <= pwdata[REG_W-1:0];
				REG_UDP_SRC_LOW: cfg_q.udp_src_port_low <= pwdata[REG_W-1:0];
				REG_UDP_SRC_HIGH: cfg_q.udp_src_port_high <= pwdata[REG_W-1:0];
				REG_USER_OFFSET: cfg_q.user_number_offset <= pwdata[REG_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			REG_UDP_DEST_PORT: prdata = DATA_W'(cfg_q.udp_dest_port);
			REG_UDP_SRC_LOW: prdata = DATA_W'(cfg_q.udp_src_port_low);
			REG_UDP_SRC_HIGH: prdata = DATA_W'(cfg_q.udp_src_port_high);
			REG_USER_OFFSET: prdata = DATA_W'(cfg_q.user_number_offset);
		endcase
	end

	// hold a last byte until the result register can take its transaction
	assign stall_s1 = valid_s1 && last_s1 && valid_s2 && !result_ready;
	assign advance = valid_s1 && !stall_s1;
	assign data_ready = !stall_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ready) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	phc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.cfg       (cfg_q),
		.result    (parse_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			result_s2 <= parse_result;
		end
	end

	assign result_valid = valid_s2;
	assign frame_class = result_s2.frame_class;
	assign source_address = result_s2.source_address;
	assign dest_address = result_s2.dest_address;
	assign user_number = result_s2.user_number;
	assign payload_start = result_s2.payload_start;
	assign frame_length = result_s2.frame_length;

	`PHC_ASSERT_IMP(a_stall_blocks_input, valid_s1 && last_s1 && valid_s2 && !result_ready,
		!data_ready, "last byte accepted over a full result register")
	`PHC_ASSERT_NXT(a_last_gives_result, advance && last_s1, result_valid,
		"last byte did not produce a result")
	`PHC_ASSERT_IMP(a_get_payload_inside, result_valid && frame_class == CLASS_GET,
		payload_start < frame_length, "payload start beyond frame end")
	`PHC_ASSERT_IMP(a_number_only_user, result_valid && frame_class != CLASS_USER,
		user_number == 32'd0, "user number set outside the user class")

endmodule

`default_nettype wire

// ===== test/packet_header_classifier_test.sv =====
`default_nettype none

module packet_header_classifier_test;
	timeunit 1ns;
	timeprecision 1ps;

	import phc_pkg::*;

	typedef enum logic [3:0] {
		P_ETHER,
		P_IPV4,
		P_TCP_HDR,
		P_GET_MATCH,
		P_UDP_HDR,
		P_HTTP_GET,
		P_UDP_MATCH,
		P_NOT_IP,
		P_IP_OTHER
	} parse_phase_e;

	typedef struct {
		logic [7:0] value;
		logic last;
		int gap;
	} frame_byte_t;

	localparam logic [31:0] GET_WORD = 32'h47455420;
	localparam int MAX_GAP = 17;
	localparam int VERDICT_WAIT = 2000;

	logic clk;
	logic arst_n;
	logic data_valid;
	logic data_ready;
	logic [7:0] data_byte;
	logic last_byte;
	logic result_valid;
	logic result_ready;
	logic [1:0] frame_class;
	logic [31:0] source_address;
	logic [31:0] dest_address;
	logic [31:0] user_number;
	logic [POS_W-1:0] payload_start;
	logic [POS_W-1:0] frame_length;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	packet_header_classifier uut (.*);

	cfg_t cls_cfg;
	logic [POS_W-1:0] at_pos;
	logic [POS_W-1:0] hdr_pos;
	parse_phase_e phase;
	logic [15:0] eth_type;
	logic [15:0] sport_acc;
	logic [15:0] dport_acc;
	logic [7:0] proto_reg;
	logic [31:0] src_acc;
	logic [31:0] dst_acc;
	logic [31:0] user_acc;
	logic [2:0] get_cnt;

	result_t verdict_q[$];
	frame_byte_t byte_q[$];
	frame_byte_t cur_byte;
	result_t want;

	int errors;
	int frames_sent;
	int bytes_sent;
	int settings_used;
	int class_seen[3];
	bit byte_accepted;
	bit result_accepted;
	bit gap_armed;
	bit result_calm;
	int wait_left;
	int stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		$display("mismatch %s: got %0h, expected %0h (t=%0t)", what, got, exp_val, $realtime);
		errors++;
	endtask

	task automatic clear_frame();
		at_pos = '0;
		hdr_pos = ETH_TYPE_POS;
		phase = P_ETHER;
		eth_type = '0;
		proto_reg = '0;
		src_acc = '0;
		dst_acc = '0;
		sport_acc = '0;
		dport_acc = '0;
		user_acc = '0;
		get_cnt = '0;
	endtask

	task automatic classify_byte(input logic [7:0] b, input logic last);
		logic [POS_W-1:0] rel;
		logic [3:0] doff;
		result_t r;
		rel = at_pos - hdr_pos;
		if (at_pos < POS_W'(MAX_FRAME_BYTES)) begin
			if (at_pos >= cls_cfg.user_number_offset &&
					at_pos - cls_cfg.user_number_offset < 4)
				user_acc = {user_acc[23:0], b};
			if (at_pos >= hdr_pos) begin
				case (phase)
					P_ETHER: begin
						if (rel == 0) begin
							eth_type = {b, 8'h00};
						end else if (rel == 1) begin
							eth_type[7:0] = b;
							if (eth_type == ETH_TYPE_VLAN) begin
								hdr_pos = hdr_pos + POS_W'(4);
							end else if (eth_type == ETH_TYPE_IPV4) begin
								hdr_pos = hdr_pos + POS_W'(2);
								phase = P_IPV4;
							end else begin
								phase = P_NOT_IP;
							end
						end
					end
					P_IPV4: begin
						if (rel == 9)
							proto_reg = b;
						else if (rel >= 12 && rel <= 15)
							src_acc = {src_acc[23:0], b};
						else if (rel >= 16 && rel <= 19)
							dst_acc = {dst_acc[23:0], b};
						if (rel == 19) begin
							hdr_pos = hdr_pos + POS_W'(20);
							if (proto_reg == IP_PROTO_TCP)
								phase = P_TCP_HDR;
							else if (proto_reg == IP_PROTO_UDP)
								phase = P_UDP_HDR;
							else
								phase = P_IP_OTHER;
						end
					end
					P_TCP_HDR: begin
						if (rel == 12) begin
							doff = b[7:4];
							if (doff < 4) begin
								phase = P_IP_OTHER;
							end else begin
								hdr_pos = hdr_pos + {doff, 2'b00};
								get_cnt = '0;
								phase = P_GET_MATCH;
							end
						end
					end
					P_GET_MATCH: begin
						if (b == GET_WORD[31 - 8 * get_cnt[1:0] -: 8]) begin
							get_cnt++;
							if (get_cnt >= 4)
								phase = P_HTTP_GET;
						end else begin
							phase = P_IP_OTHER;
						end
					end
					P_UDP_HDR: begin
						if (rel <= 1)
							sport_acc = {sport_acc[7:0], b};
						else if (rel <= 3)
							dport_acc = {dport_acc[7:0], b};
						if (rel == 3) begin
							if (dport_acc == cls_cfg.udp_dest_port &&
									sport_acc >= cls_cfg.udp_src_port_low &&
									sport_acc <= cls_cfg.udp_src_port_high)
								phase = P_UDP_MATCH;
							else
								phase = P_IP_OTHER;
						end
					end
					default: ;
				endcase
			end
			at_pos++;
		end
		if (last) begin
			r = '0;
			r.frame_class = CLASS_DROP;
			r.frame_length = at_pos;
			if (!(phase inside {P_ETHER, P_IPV4, P_NOT_IP})) begin
				r.source_address = src_acc;
				r.dest_address = dst_acc;
			end
			if (phase == P_HTTP_GET) begin
				r.frame_class = CLASS_GET;
				r.payload_start = hdr_pos;
			end else if (phase == P_UDP_MATCH &&
					int'(at_pos) >= int'(cls_cfg.user_number_offset) + 4) begin
				r.frame_class = CLASS_USER;
				r.user_number = user_acc;
			end
			verdict_q.push_back(r);
			clear_frame();
		end
	endtask

	// monitor: sample both channels at the rising edge
	always @(posedge clk) begin
		byte_accepted = data_valid && data_ready;
		result_accepted = result_valid && result_ready;
		if (byte_accepted) begin
			classify_byte(data_byte, last_byte);
			bytes_sent++;
		end
		if (result_accepted) begin
			if (verdict_q.size() == 0) begin
				report_mismatch("unexpected result, class", 64'(frame_class), 64'd0);
			end else begin
				want = verdict_q.pop_front();
				if (frame_class !== want.frame_class)
					report_mismatch("frame_class", 64'(frame_class),
						64'(want.frame_class));
				if (source_address !== want.source_address)
					report_mismatch("source_address", 64'(source_address),
						64'(want.source_address));
				if (dest_address !== want.dest_address)
					report_mismatch("dest_address", 64'(dest_address),
						64'(want.dest_address));
				if (user_number !== want.user_number)
					report_mismatch("user_number", 64'(user_number),
						64'(want.user_number));
				if (payload_start !== want.payload_start)
					report_mismatch("payload_start", 64'(payload_start),
						64'(want.payload_start));
				if (frame_length !== want.frame_length)
					report_mismatch("frame_length", 64'(frame_length),
						64'(want.frame_length));
				if (want.frame_class <= CLASS_USER)
					class_seen[want.frame_class]++;
			end
		end
	end

	// byte driver: hold each transaction until accepted, then wait out the next gap
	always @(negedge clk) begin
		if (!data_valid || byte_accepted) begin
			if (!gap_armed && byte_q.size() > 0) begin
				wait_left = byte_q[0].gap;
				gap_armed = 1'b1;
			end
			if (gap_armed && wait_left == 0) begin
				cur_byte = byte_q.pop_front();
				data_valid <= 1'b1;
				data_byte <= cur_byte.value;
				last_byte <= cur_byte.last;
				gap_armed = 1'b0;
			end else begin
				data_valid <= 1'b0;
				if (gap_armed)
					wait_left--;
			end
		end
	end

	// result side: stall a random number of cycles after each transaction
	always @(negedge clk) begin
		if (result_accepted) begin
			if ($urandom_range(0, 7) == 0)
				result_calm = ~result_calm;
			stall_left = result_calm ? 0 : $urandom_range(0, MAX_GAP);
		end
		if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left--;
		end else begin
			result_ready <= 1'b1;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= DATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_UDP_DEST_PORT: cls_cfg.udp_dest_port = val;
			REG_UDP_SRC_LOW: cls_cfg.udp_src_port_low = val;
			REG_UDP_SRC_HIGH: cls_cfg.udp_src_port_high = val;
			REG_USER_OFFSET: cls_cfg.user_number_offset = val;
			default: ;
		endcase
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== DATA_W'(val))
			report_mismatch("register readback", 64'(prdata), 64'(val));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_setting(input logic [15:0] dport, input logic [15:0] lo,
			input logic [15:0] hi, input logic [15:0] offs);
		write_reg(REG_UDP_DEST_PORT, dport);
		write_reg(REG_UDP_SRC_LOW, lo);
		write_reg(REG_UDP_SRC_HIGH, hi);
		write_reg(REG_USER_OFFSET, offs);
		settings_used++;
	endtask

	task automatic drain();
		int spins;
		spins = 0;
		while (byte_q.size() != 0 || data_valid)
			@(posedge clk);
		while (verdict_q.size() != 0 && spins < VERDICT_WAIT) begin
			@(posedge clk);
			spins++;
		end
		repeat (4) @(posedge clk);
		if (verdict_q.size() != 0) begin
			report_mismatch("results never delivered", 64'(verdict_q.size()), 64'd0);
			verdict_q.delete();
		end
	endtask

	task automatic queue_frame(input int tags, input logic [15:0] etype, input logic [7:0] proto,
			input logic [3:0] doff, input int get_len, input logic [15:0] sport,
			input logic [15:0] dport, input int tail, input int cut, input bit burst);
		logic [7:0] f[$];
		int hdr_len;
		bit calm;
		frame_byte_t item;
		repeat (12) f.push_back(8'($urandom));
		repeat (tags) begin
			f.push_back(ETH_TYPE_VLAN[15:8]);
			f.push_back(ETH_TYPE_VLAN[7:0]);
			f.push_back(8'($urandom));
			f.push_back(8'($urandom));
		end
		f.push_back(etype[15:8]);
		f.push_back(etype[7:0]);
		for (int i = 0; i < 20; i++)
			f.push_back(i == 0 ? 8'h45 : (i == 9 ? proto : 8'($urandom)));
		if (proto == IP_PROTO_TCP) begin
			hdr_len = doff >= 4 ? 4 * doff : 20;
			for (int i = 0; i < hdr_len; i++)
				f.push_back(i == 12 ? {doff, 4'($urandom)} : 8'($urandom));
			for (int i = 0; i < get_len && i < 4; i++)
				f.push_back(GET_WORD[31 - 8 * i -: 8]);
			if (get_len < 4)
				f.push_back(GET_WORD[31 - 8 * get_len -: 8] ^ 8'($urandom_range(1, 255)));
		end else if (proto == IP_PROTO_UDP) begin
			f.push_back(sport[15:8]);
			f.push_back(sport[7:0]);
			f.push_back(dport[15:8]);
			f.push_back(dport[7:0]);
			repeat (4) f.push_back(8'($urandom));
		end
		repeat (tail) f.push_back(8'($urandom));
		if (cut > 0 && cut < f.size())
			f = f[0:cut-1];
		calm = burst || $urandom_range(0, 3) == 0;
		foreach (f[i]) begin
			item.value = f[i];
			item.last = (i == f.size() - 1);
			item.gap = calm ? 0 : $urandom_range(0, MAX_GAP);
			byte_q.push_back(item);
		end
		frames_sent++;
	endtask

	task automatic random_frame();
		int pick;
		int tags;
		int get_len;
		int cut;
		logic [15:0] etype;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0] proto;
		logic [3:0] doff;
		pick = $urandom_range(0, 9);
		tags = pick < 6 ? 0 : pick - 5;
		etype = $urandom_range(0, 9) == 0 ? 16'($urandom) : ETH_TYPE_IPV4;
		pick = $urandom_range(0, 19);
		proto = pick < 9 ? IP_PROTO_TCP : (pick < 18 ? IP_PROTO_UDP : 8'($urandom));
		doff = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(5, 8));
		get_len = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : 4;
		pick = $urandom_range(0, 9);
		if (pick < 6 && cls_cfg.udp_src_port_low <= cls_cfg.udp_src_port_high)
			sport = 16'($urandom_range(cls_cfg.udp_src_port_low, cls_cfg.udp_src_port_high));
		else if (pick == 6)
			sport = cls_cfg.udp_src_port_low - 16'd1;
		else if (pick == 7)
			sport = cls_cfg.udp_src_port_high + 16'd1;
		else if (pick == 8)
			sport = $urandom_range(0, 1) ? cls_cfg.udp_src_port_low : cls_cfg.udp_src_port_high;
		else
			sport = 16'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 8)
			dport = cls_cfg.udp_dest_port;
		else if (pick == 8)
			dport = cls_cfg.udp_dest_port ^ 16'(1 << $urandom_range(0, 15));
		else
			dport = 16'($urandom);
		cut = $urandom_range(0, 5) == 0 ? $urandom_range(1, 80) : 0;
		queue_frame(tags, etype, proto, doff, get_len, sport, dport, $urandom_range(0, 12), cut,
			1'b0);
	endtask

	initial begin
		arst_n = 1'b0;
		data_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		result_ready = 1'b1;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cls_cfg = CFG_RESET;
		clear_frame();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: port 8000, window 4000..4100, user number at 49
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_UDP, 0, 0, 16'd4000, 16'd8000, 20, 0, 1'b0);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_UDP, 0, 0, 16'd4100, 16'd8000, 11, 0, 1'b0);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_UDP, 0, 0, 16'd4050, 16'd8000, 10, 0, 1'b0);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_UDP, 0, 0, 16'd3999, 16'd8000, 20, 0, 1'b0);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_UDP, 0, 0, 16'd4101, 16'd8000, 20, 0, 1'b0);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_UDP, 0, 0, 16'd4000, 16'd8001, 20, 0, 1'b0);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd5, 4, 0, 0, 10, 0, 1'b0);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd15, 4, 0, 0, 0, 0, 1'b0);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd4, 4, 0, 0, 3, 0, 1'b0);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd3, 4, 0, 0, 3, 0, 1'b0);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd0, 4, 0, 0, 3, 0, 1'b0);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd5, 3, 0, 0, 5, 0, 1'b0);
		queue_frame(1, ETH_TYPE_IPV4, IP_PROTO_UDP, 0, 0, 16'd4001, 16'd8000, 30, 0, 1'b0);
		queue_frame(3, ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd6, 4, 0, 0, 8, 0, 1'b0);
		queue_frame(0, 16'h86DD, IP_PROTO_UDP, 0, 0, 16'd4000, 16'd8000, 20, 0, 1'b0);
		queue_frame(0, 16'h0000, IP_PROTO_TCP, 4'd5, 4, 0, 0, 4, 0, 1'b0);
		queue_frame(0, ETH_TYPE_IPV4, 8'd1, 0, 0, 0, 0, 8, 0, 1'b0);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_UDP, 0, 0, 16'd4000, 16'd8000, 20, 20, 1'b0);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd5, 4, 0, 0, 4, 33, 1'b0);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd5, 4, 0, 0, 4, 34, 1'b0);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd5, 4, 0, 0, 4, 1, 1'b0);
		drain();

		// widest window, user number taken from the first bytes of the frame
		write_setting(16'd0, 16'd0, 16'hFFFF, 16'd0);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_UDP, 0, 0, 16'd0, 16'd0, 5, 0, 1'b0);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_UDP, 0, 0, 16'hFFFF, 16'd0, 0, 0, 1'b0);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd5, 4, 0, 0, 2, 0, 1'b0);
		drain();

		// top values; the user number lies past the end of the frame
		write_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd65532);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_UDP, 0, 0, 16'hFFFF, 16'hFFFF, 10, 0, 1'b0);
		drain();

		// inverted window matches nothing
		write_setting(16'd8000, 16'd5000, 16'd4000, 16'd49);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_UDP, 0, 0, 16'd4500, 16'd8000, 20, 0, 1'b0);
		queue_frame(0, ETH_TYPE_IPV4, IP_PROTO_UDP, 0, 0, 16'd5000, 16'd8000, 20, 0, 1'b0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			logic [15:0] lo;
			lo = 16'($urandom);
			write_setting(16'($urandom), lo,
				$urandom_range(0, 4) == 0 ? 16'($urandom) :
				(lo > 16'd65235 ? 16'hFFFF : lo + 16'($urandom_range(0, 300))),
				$urandom_range(0, 7) == 0 ? 16'($urandom_range(0, 65532)) :
				16'($urandom_range(0, 110)));
			repeat (2) random_frame();
			drain();
		end

		$display("covered %0d frames, %0d bytes, %0d register settings", frames_sent,
			bytes_sent, settings_used + 1);
		$display("results: %0d dropped, %0d GET requests, %0d user-number messages",
			class_seen[0], class_seen[1], class_seen[2]);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
